// ----- rtl/core/emb64_pkg.sv -----
// Shared constants, types and symbol functions for the emoji Base64 codec.
package emb64_pkg;

  localparam logic ModeEncode = 1'b0;
  localparam logic ModeDecode = 1'b1;

  localparam logic RegMode = 1'b0;

  localparam logic [20:0] SymBaseCp = 21'h1F5FB;
  localparam logic [20:0] PadCp     = 21'h1F47E;
  localparam logic [6:0]  PadIndex  = 7'd64;
  localparam logic [19:0] SymCount  = 20'd64;

  localparam logic [3:0] EncLast  = 4'd2;
  localparam logic [3:0] DecLast  = 4'd15;
  localparam logic [4:0] EncCount = 5'd16;

  typedef logic [15:0][7:0] group_t;

  typedef struct packed {
    group_t     data;
    logic [4:0] count;
  } burst_t;

  // Four UTF-8 bytes of a code point, first byte in the low bits.
  function automatic logic [31:0] utf8_char(input logic [20:0] cp);
    utf8_char = {2'b10, cp[5:0], 2'b10, cp[11:6], 2'b10, cp[17:12], 5'b11110, cp[20:18]};
  endfunction

  function automatic logic [20:0] sym_cp(input logic [5:0] idx);
    sym_cp = SymBaseCp + {15'd0, idx};
  endfunction

  // Map the 20 value bits of one character to 0..63, or to the pad index.
  function automatic logic [6:0] char_index(input logic [31:0] c);
    logic [19:0] v;
    logic [19:0] off;
    v   = {c[1:0], c[13:8], c[21:16], c[29:24]};
    off = v - SymBaseCp[19:0];
    if (v >= SymBaseCp[19:0] && off < SymCount) begin
      char_index = {1'b0, off[5:0]};
    end else begin
      char_index = PadIndex;
    end
  endfunction

endpackage

// ----- rtl/core/emb64_fmt.sv -----
// Group formatter: turns a complete group into its burst of result bytes.
module emb64_fmt (
  input  logic                  mode_i,
  input  emb64_pkg::group_t     group_i,
  input  logic [3:0]            fill_i,
  output emb64_pkg::burst_t     burst_o
);

  logic       have2;
  logic       have3;
  logic [7:0] b0;
  logic [7:0] b1;
  logic [7:0] b2;
  logic [6:0] p0;
  logic [6:0] p1;
  logic [6:0] p2;
  logic [6:0] p3;

  always_comb begin
    have2 = fill_i >= 4'd1;
    have3 = fill_i >= 4'd2;
    b0    = group_i[0];
    b1    = have2 ? group_i[1] : 8'h00;
    b2    = have3 ? group_i[2] : 8'h00;
    p0    = emb64_pkg::char_index(group_i[3:0]);
    p1    = emb64_pkg::char_index(group_i[7:4]);
    p2    = emb64_pkg::char_index(group_i[11:8]);
    p3    = emb64_pkg::char_index(group_i[15:12]);
    burst_o = '0;
    case (mode_i)
      emb64_pkg::ModeEncode: begin
        burst_o.data[3:0]   = emb64_pkg::utf8_char(emb64_pkg::sym_cp(b0[7:2]));
        burst_o.data[7:4]   = emb64_pkg::utf8_char(emb64_pkg::sym_cp({b0[1:0], b1[7:4]}));
        burst_o.data[11:8]  = have2 ?
            emb64_pkg::utf8_char(emb64_pkg::sym_cp({b1[3:0], b2[7:6]})) :
            emb64_pkg::utf8_char(emb64_pkg::PadCp);
        burst_o.data[15:12] = have3 ?
            emb64_pkg::utf8_char(emb64_pkg::sym_cp(b2[5:0])) :
            emb64_pkg::utf8_char(emb64_pkg::PadCp);
        burst_o.count       = emb64_pkg::EncCount;
      end
      emb64_pkg::ModeDecode: begin
        burst_o.data[0] = {p0[5:0], p1[5:4]};
        burst_o.data[1] = {p1[3:0], p2[5:2]};
        burst_o.data[2] = {p2[1], p2[0] | p3[6], p3[5:0]};
        if (p2 == emb64_pkg::PadIndex) begin
          burst_o.count = 5'd1;
        end else if (p3 == emb64_pkg::PadIndex) begin
          burst_o.count = 5'd2;
        end else begin
          burst_o.count = 5'd3;
        end
      end
      default: begin
        burst_o = '0;
      end
    endcase
  end

endmodule

// ----- rtl/core/emoji_base64_codec_unit.sv -----
// Emoji Base64 codec top level: input register, group store, burst buffer, APB register.
//
// Streams bytes in on s_axis (tlast ends the stream) and bytes out on m_axis (tlast marks
// the final byte caused by one input transaction). Register mode at address 0 selects
// encode (0) or decode (1); writing it discards a partial group. The user must write it
// only while idle; the block itself does not enforce this. Input transactions that do
// not complete a group are taken every cycle. A completing transaction loads a burst
// buffer that sends one byte per cycle while m_axis_tready is high, and it waits in the
// input register until that buffer is empty. Encode: a 3-byte group gives 16 bytes, so
// the output serializer sets the rate. Decode: 16 input bytes give 1 to 3 bytes,
// sustaining one input byte per cycle while the output does not stall.
module emoji_base64_codec_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic              mode_q;
  logic              in_vld_q;
  logic [7:0]        in_byte_q;
  logic              in_eos_q;
  logic [3:0]        fill_q;
  logic [3:0]        fill_d;
  emb64_pkg::group_t store_q;
  emb64_pkg::group_t grp;
  emb64_pkg::group_t obuf_q;
  logic [4:0]        rem_q;
  logic [3:0]        eff_fill;
  logic              done;
  logic              advance;
  logic              load;
  logic              xfer;
  logic              cfg_wr;
  emb64_pkg::burst_t burst;

  assign pready = 1'b1;
  assign prdata = {31'd0, mode_q};
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == emb64_pkg::RegMode);

  always_comb begin
    eff_fill = fill_q;
    if (mode_q == emb64_pkg::ModeEncode && fill_q > emb64_pkg::EncLast) begin
      eff_fill = 4'd0;
    end
    if (mode_q == emb64_pkg::ModeEncode) begin
      done = (eff_fill == emb64_pkg::EncLast) || in_eos_q;
    end else begin
      done = eff_fill == emb64_pkg::DecLast;
    end
    for (int k = 0; k < 16; k++) begin
      grp[k] = (eff_fill == 4'(k)) ? in_byte_q : store_q[k];
    end
    advance = in_vld_q && (!done || rem_q == 5'd0);
    load    = advance && done;
    fill_d  = (done || in_eos_q) ? 4'd0 : eff_fill + 4'd1;
  end

  assign s_axis_tready = !in_vld_q || advance;
  assign m_axis_tvalid = rem_q != 5'd0;
  assign m_axis_tdata  = obuf_q[0];
  assign m_axis_tlast  = rem_q == 5'd1;
  assign xfer          = m_axis_tvalid && m_axis_tready;

  emb64_fmt u_fmt (
    .mode_i  (mode_q),
    .group_i (grp),
    .fill_i  (eff_fill),
    .burst_o (burst)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= emb64_pkg::ModeEncode;
      in_vld_q <= 1'b0;
      fill_q   <= 4'd0;
      rem_q    <= 5'd0;
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (cfg_wr) begin
        mode_q <= pwdata[0];
        fill_q <= 4'd0;
      end else if (advance) begin
        fill_q <= fill_d;
      end
      if (load) begin
        rem_q <= burst.count;
      end else if (xfer) begin
        rem_q <= rem_q - 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_eos_q  <= s_axis_tlast;
    end
    if (advance) begin
      store_q[eff_fill] <= in_byte_q;
    end
    if (load) begin
      obuf_q <= burst.data;
    end else if (xfer) begin
      obuf_q <= {8'h00, obuf_q[15:1]};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) rem_q <= emb64_pkg::EncCount)
    else $error("burst count above group size");

  assert property (@(posedge clk_i) disable iff (!rst_ni) load |-> rem_q == 5'd0)
    else $error("burst loaded over pending bytes");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      xfer && m_axis_tlast |=> !m_axis_tvalid)
    else $error("output valid right after final byte of a burst");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      load && mode_q == emb64_pkg::ModeDecode |=> rem_q >= 5'd1 && rem_q <= 5'd3)
    else $error("decode burst length out of range");

endmodule

// ----- bench/emoji_base64_codec_unit_tb.sv -----
// Self-checking testbench for the emoji Base64 codec: directed table, random streams, APB mode.
module emoji_base64_codec_unit_tb;

  localparam logic [20:0] CpFirst    = 21'h1F5FB;
  localparam logic [20:0] CpPad      = 21'h1F47E;
  localparam logic [6:0]  NoSymbol   = 7'd64;
  localparam logic [2:0]  AddrMode   = 3'd0;
  localparam logic [2:0]  AddrSpare  = 3'd4;
  localparam int          CycleLimit = 200000;
  localparam int          HoldCycles = 400;

  // characters as they appear on the stream, first byte in the low bits
  localparam logic [31:0] ChrSym0    = 32'hBB97_9FF0;
  localparam logic [31:0] ChrSym63   = 32'hBA98_9FF0;
  localparam logic [31:0] ChrPad     = 32'hBE91_9FF0;
  localparam logic [31:0] ChrPast    = 32'hBB98_9FF0;
  localparam logic [31:0] ChrSym0Odd = 32'h3BD7_5F7C;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_byte_t;

  typedef struct packed {
    logic [15:0][7:0] bytes;
    logic [4:0]       n;
  } emit_t;

  typedef struct {
    logic             mode;
    int               nb;
    logic [15:0][7:0] data;
    logic             eos;
    int               en;
    logic [15:0][7:0] ex;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] in_byte
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // [7:0] out_byte
  logic        m_axis_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  logic        pr_mode;
  logic [7:0]  pr_store [16];
  int          pr_fill;

  out_byte_t   pending_out [$];
  row_t        rows [$];
  int          mismatches = 0;
  int          cycles = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  logic        hold_req = 1'b0;

  emoji_base64_codec_unit dut (
    .clk_i         (clk),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] utf8_of(input logic [20:0] cp);
    logic [3:0][7:0] c;
    c[0] = {5'b11110, cp[20:18]};
    c[1] = {2'b10, cp[17:12]};
    c[2] = {2'b10, cp[11:6]};
    c[3] = {2'b10, cp[5:0]};
    return c;
  endfunction

  function automatic emit_t codec_step(input logic [7:0] b, input logic eos);
    emit_t            r;
    logic [7:0]       b0, b1, b2;
    logic [3:0][5:0]  sy;
    logic [20:0]      cp;
    logic [31:0]      chr;
    logic [19:0]      v, off;
    logic [3:0][6:0]  ix;
    r = '0;
    if (pr_mode == emb64_pkg::ModeEncode) begin
      if (pr_fill >= 3) pr_fill = 0;
      pr_store[pr_fill] = b;
      pr_fill++;
      if (pr_fill == 3 || eos) begin
        b0 = pr_store[0];
        b1 = (pr_fill > 1) ? pr_store[1] : 8'd0;
        b2 = (pr_fill > 2) ? pr_store[2] : 8'd0;
        sy[0] = b0[7:2];
        sy[1] = {b0[1:0], b1[7:4]};
        sy[2] = {b1[3:0], b2[7:6]};
        sy[3] = b2[5:0];
        for (int c = 0; c < 4; c++) begin
          if ((c == 2 && pr_fill < 2) || (c == 3 && pr_fill < 3)) begin
            cp = CpPad;
          end else begin
            cp = CpFirst + {15'd0, sy[c]};
          end
          chr = utf8_of(cp);
          for (int k = 0; k < 4; k++) r.bytes[4*c+k] = chr[8*k +: 8];
        end
        r.n = 5'd16;
        pr_fill = 0;
      end
    end else begin
      pr_store[pr_fill] = b;
      pr_fill++;
      if (pr_fill == 16) begin
        for (int c = 0; c < 4; c++) begin
          v = {pr_store[4*c][1:0], pr_store[4*c+1][5:0], pr_store[4*c+2][5:0],
               pr_store[4*c+3][5:0]};
          off = v - CpFirst[19:0];
          ix[c] = (v >= CpFirst[19:0] && off < 20'd64) ? {1'b0, off[5:0]} : NoSymbol;
        end
        r.bytes[0] = {ix[0][5:0], ix[1][5:4]};
        r.bytes[1] = {ix[1][3:0], ix[2][5:2]};
        r.bytes[2] = {ix[2][1:0], 6'd0} | {1'b0, ix[3]};
        r.n = (ix[3] == NoSymbol) ? 5'd2 : 5'd3;
        if (ix[2] == NoSymbol) r.n = 5'd1;
        pr_fill = 0;
      end else if (eos) begin
        pr_fill = 0;
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] rand_char();
    int unsigned pick;
    logic [31:0] c;
    pick = $urandom_range(0, 9);
    if (pick == 8) begin
      c = utf8_of(CpPad);
    end else begin
      c = utf8_of(CpFirst + 21'($urandom_range(0, 63)));
    end
    if (pick == 7) c = c ^ ($urandom & 32'hC0C0_C0FC);
    if (pick == 9) c = $urandom;
    return c;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eos, input int typed_n,
                           input logic [15:0][7:0] typed_bytes);
    emit_t r;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eos;
    do @(posedge clk); while (!s_axis_tready);
    r = codec_step(b, eos);
    if (typed_n >= 0) begin
      r.bytes = typed_bytes;
      r.n     = 5'(typed_n);
    end
    for (int k = 0; k < r.n; k++) pending_out.push_back('{r.bytes[k], k == r.n - 1});
    @(negedge clk);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending_out.size() != 0);
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == AddrMode) begin
      pr_mode = data[0];
      pr_fill = 0;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_mode(input logic m);
    logic [31:0] got;
    wait_drained();
    reg_write(AddrMode, ($urandom & ~32'd1) | {31'd0, m});
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= AddrMode;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    if (got !== {31'd0, pr_mode}) begin
      mismatches++;
      if (mismatches <= 10) $display("mode readback: expected %0b, got %08h", pr_mode, got);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        for (int i = 0; i < HoldCycles; i++) @(negedge clk);
      end
      m_axis_tready <= !($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    out_byte_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_out.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected output: %02h last %0b", m_axis_tdata, m_axis_tlast);
        end
      end else begin
        want = pending_out.pop_front();
        if (m_axis_tdata !== want.data || m_axis_tlast !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("output mismatch: expected %02h last %0b, got %02h last %0b",
                     want.data, want.last, m_axis_tdata, m_axis_tlast);
          end
        end
      end
    end
  end

  initial begin
    logic [3:0][31:0] grp;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    pr_mode       = emb64_pkg::ModeEncode;
    pr_fill       = 0;
    foreach (pr_store[i]) pr_store[i] = '0;

    rows.push_back('{emb64_pkg::ModeEncode, 3, 128'h0, 1'b0, 16, {4{ChrSym0}}});
    rows.push_back('{emb64_pkg::ModeEncode, 3, 128'hFF_FFFF, 1'b1, 16, {4{ChrSym63}}});
    rows.push_back('{emb64_pkg::ModeEncode, 1, 128'h0, 1'b1, 16,
                     {ChrPad, ChrPad, ChrSym0, ChrSym0}});
    rows.push_back('{emb64_pkg::ModeEncode, 2, 128'h5AA5, 1'b1, -1, 128'h0});
    rows.push_back('{emb64_pkg::ModeEncode, 2, 128'h1234, 1'b0, -1, 128'h0});
    rows.push_back('{emb64_pkg::ModeDecode, 16, {4{ChrPad}}, 1'b0, 1, 128'h0});
    rows.push_back('{emb64_pkg::ModeDecode, 16, {ChrPad, ChrSym63, ChrPast, ChrSym0Odd},
                     1'b1, -1, 128'h0});
    rows.push_back('{emb64_pkg::ModeDecode, 5, 128'h80_BA98_9FF0, 1'b1, 0, 128'h0});

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;
    @(negedge clk);

    reg_write(AddrSpare, 32'hFFFF_FFFF);
    set_mode(emb64_pkg::ModeEncode);

    foreach (rows[r]) begin
      if (rows[r].mode != pr_mode) set_mode(rows[r].mode);
      for (int i = 0; i < rows[r].nb; i++) begin
        send_byte(rows[r].data[i], rows[r].eos && i == rows[r].nb - 1,
                  (i == rows[r].nb - 1) ? rows[r].en : -1, rows[r].ex);
      end
    end

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = (p == 1) ? 57 : (p == 3) ? 27 : 0;
      recv_stall_pct = (p == 2) ? 57 : (p == 3) ? 27 : 0;
      set_mode(emb64_pkg::ModeEncode);
      if (p == 0) begin
        @(posedge clk);
        hold_req = 1'b1;
        @(negedge clk);
      end
      repeat (4) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 4) == 0, -1, '0);
      if (p != 0) begin
        set_mode(emb64_pkg::ModeDecode);
        for (int c = 0; c < 4; c++) grp[c] = rand_char();
        for (int i = 0; i < 16; i++) begin
          send_byte(grp[i/4][8*(i%4) +: 8], i == 15 && $urandom_range(0, 1) == 1, -1, '0);
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending_out.size() != 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_out.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/emb64_pkg.sv
rtl/core/emb64_fmt.sv
rtl/core/emoji_base64_codec_unit.sv
bench/emoji_base64_codec_unit_tb.sv
